// ----- hw/rtl/fwrf_pkg.sv -----
// Shared constants, types and the CRC step function of the flash write report framer.
package fwrf_pkg;

    localparam int CHUNK_BYTES   = 46;
    localparam int REPORT_BYTES  = 64;
    localparam int PAYLOAD_START = 17;

    localparam int BYTE_W  = 8;
    localparam int IDX_W   = $clog2(REPORT_BYTES);
    localparam int FILL_W  = $clog2(CHUNK_BYTES + 1);
    localparam int ADDR_W  = $clog2(CHUNK_BYTES);
    localparam int CRC_W   = 16;
    localparam int WORD_W  = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ID     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_COMMAND = 2'd3;

    localparam logic [BYTE_W-1:0]   RESET_REPORT_ID     = 8'd5;
    localparam logic [2*BYTE_W-1:0] RESET_WRITE_COMMAND = 16'd3;

    // header byte positions
    localparam logic [IDX_W-1:0] POS_ID      = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_CMD_LO  = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_CMD_HI  = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_LEN_LO  = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_CRC_LO  = IDX_W'(7);
    localparam logic [IDX_W-1:0] POS_CRC_HI  = IDX_W'(8);
    localparam logic [IDX_W-1:0] POS_IMG_B0  = IDX_W'(9);
    localparam logic [IDX_W-1:0] POS_IMG_B1  = IDX_W'(10);
    localparam logic [IDX_W-1:0] POS_IMG_B2  = IDX_W'(11);
    localparam logic [IDX_W-1:0] POS_IMG_B3  = IDX_W'(12);
    localparam logic [IDX_W-1:0] POS_OFS_B0  = IDX_W'(13);
    localparam logic [IDX_W-1:0] POS_OFS_B1  = IDX_W'(14);
    localparam logic [IDX_W-1:0] POS_OFS_B2  = IDX_W'(15);
    localparam logic [IDX_W-1:0] POS_OFS_B3  = IDX_W'(16);
    localparam logic [IDX_W-1:0] POS_PAYLOAD = IDX_W'(PAYLOAD_START);
    localparam logic [IDX_W-1:0] POS_LAST    = IDX_W'(REPORT_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EMIT = 2'b10
    } fwrf_state_t;

    typedef struct packed {
        logic             accept;
        logic             load;
        logic [IDX_W-1:0] load_idx;
        logic [IDX_W-1:0] rd_idx;
        logic             finish;
    } fwrf_cmd_t;

    typedef struct packed {
        logic close;
        logic out_free;
    } fwrf_status_t;

    function automatic logic [CRC_W-1:0] crc_add(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int b = 0; b < BYTE_W; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/fwrf_in_if.sv -----
// Input item channel: one image byte with its last flag.
interface fwrf_in_if
    import fwrf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink   (input valid, input data_byte, input is_last, output ready);
endinterface

// ----- hw/rtl/fwrf_out_if.sv -----
// Output item channel: one report byte with position and end flags.
interface fwrf_out_if
    import fwrf_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] report_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              end_of_report;
    logic              end_of_image;

    modport source (output valid, output report_byte, output byte_index,
                    output end_of_report, output end_of_image, input ready);
    modport sink   (input valid, input report_byte, input byte_index,
                    input end_of_report, input end_of_image, output ready);
endinterface

// ----- hw/rtl/fwrf_ctrl.sv -----
// Controller: collect/emit state machine and report byte counter.
module fwrf_ctrl
    import fwrf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  fwrf_status_t status,
    output fwrf_cmd_t    cmd
);

    fwrf_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             accept;
    logic             load;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign load     = (state_reg == ST_EMIT) && status.out_free;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && status.close)
                begin
                    state_next = ST_EMIT;
                    idx_next   = '0;
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_reg == POS_LAST)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign cmd.accept   = accept;
    assign cmd.load     = load;
    assign cmd.load_idx = idx_reg;
    assign cmd.rd_idx   = idx_next;
    assign cmd.finish   = load && (idx_reg == POS_LAST);

    a_close_starts_report: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && status.close) |=> (state_reg == ST_EMIT) && (idx_reg == '0))
        else $error("closing byte did not start a report");

    a_last_byte_ends_report: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == ST_IDLE))
        else $error("report did not end after its last byte");

    a_counter_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_EMIT) && !load) |=> $stable(idx_reg))
        else $error("byte counter moved while output stalled");

endmodule

// ----- hw/rtl/fwrf_datapath.sv -----
// Datapath: config registers, chunk memory, CRC, header mux and output register.
module fwrf_datapath
    import fwrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic [BYTE_W-1:0]    in_byte,
    input  logic                 in_last,
    input  fwrf_cmd_t            cmd,
    output fwrf_status_t         status,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    out_byte,
    output logic [IDX_W-1:0]     out_idx,
    output logic                 out_eor,
    output logic                 out_eoi
);

    logic [WORD_W-1:0]   base_reg;
    logic [WORD_W-1:0]   image_len_reg;
    logic [BYTE_W-1:0]   report_id_reg;
    logic [2*BYTE_W-1:0] write_cmd_reg;

    logic [BYTE_W-1:0] chunk_mem [CHUNK_BYTES];
    logic [BYTE_W-1:0] rd_data_reg;

    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [WORD_W-1:0] done_reg, done_next;
    logic              last_reg, last_next;

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [IDX_W-1:0]  out_idx_reg;
    logic              out_eor_reg;
    logic              out_eoi_reg;

    logic [FILL_W-1:0] fill_inc;
    logic [IDX_W-1:0]  rd_off;
    logic [IDX_W-1:0]  pay_off;
    logic              pay_ok;
    logic [WORD_W-1:0] offset;
    logic [BYTE_W-1:0] byte_val;
    logic              at_last;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            image_len_reg <= '0;
            report_id_reg <= RESET_REPORT_ID;
            write_cmd_reg <= RESET_WRITE_COMMAND;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_BASE_ADDRESS:  base_reg      <= cfg_data;
                CFG_IMAGE_LENGTH:  image_len_reg <= cfg_data;
                CFG_REPORT_ID:     report_id_reg <= cfg_data[BYTE_W-1:0];
                CFG_WRITE_COMMAND: write_cmd_reg <= cfg_data[2*BYTE_W-1:0];
                default:           ;
            endcase
        end
    end

    // chunk memory
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (fill_reg < FILL_W'(CHUNK_BYTES)))
        begin
            chunk_mem[fill_reg[ADDR_W-1:0]] <= in_byte;
        end
    end

    assign rd_off = cmd.rd_idx - POS_PAYLOAD;

    always_ff @(posedge clk)
    begin
        if (rd_off < IDX_W'(CHUNK_BYTES))
        begin
            rd_data_reg <= chunk_mem[rd_off[ADDR_W-1:0]];
        end
    end

    // chunk state
    assign fill_inc     = fill_reg + FILL_W'(1);
    assign status.close = (fill_inc == FILL_W'(CHUNK_BYTES)) || in_last;

    always_comb
    begin
        fill_next = fill_reg;
        crc_next  = crc_reg;
        done_next = done_reg;
        last_next = last_reg;
        priority if (cmd.finish)
        begin
            fill_next = '0;
            crc_next  = CRC_INIT;
            done_next = done_reg + WORD_W'(fill_reg);
        end
        else if (cmd.accept)
        begin
            fill_next = fill_inc;
            crc_next  = crc_add(crc_reg, in_byte);
            last_next = in_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            crc_reg  <= CRC_INIT;
            done_reg <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            crc_reg  <= crc_next;
            done_reg <= done_next;
            last_reg <= last_next;
        end
    end

    // report byte select
    assign offset  = base_reg + done_reg;
    assign pay_off = cmd.load_idx - POS_PAYLOAD;
    assign pay_ok  = (cmd.load_idx >= POS_PAYLOAD) && (pay_off < IDX_W'(fill_reg));
    assign at_last = (cmd.load_idx == POS_LAST);

    always_comb
    begin
        unique case (cmd.load_idx)
            POS_ID:     byte_val = report_id_reg;
            POS_CMD_LO: byte_val = write_cmd_reg[BYTE_W-1:0];
            POS_CMD_HI: byte_val = write_cmd_reg[2*BYTE_W-1:BYTE_W];
            POS_LEN_LO: byte_val = BYTE_W'(fill_reg);
            POS_CRC_LO: byte_val = crc_reg[BYTE_W-1:0];
            POS_CRC_HI: byte_val = crc_reg[2*BYTE_W-1:BYTE_W];
            POS_IMG_B0: byte_val = image_len_reg[BYTE_W-1:0];
            POS_IMG_B1: byte_val = image_len_reg[2*BYTE_W-1:BYTE_W];
            POS_IMG_B2: byte_val = image_len_reg[3*BYTE_W-1:2*BYTE_W];
            POS_IMG_B3: byte_val = image_len_reg[4*BYTE_W-1:3*BYTE_W];
            POS_OFS_B0: byte_val = offset[BYTE_W-1:0];
            POS_OFS_B1: byte_val = offset[2*BYTE_W-1:BYTE_W];
            POS_OFS_B2: byte_val = offset[3*BYTE_W-1:2*BYTE_W];
            POS_OFS_B3: byte_val = offset[4*BYTE_W-1:3*BYTE_W];
            default:    byte_val = pay_ok ? rd_data_reg : '0;
        endcase
    end

    // output register
    assign status.out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        priority if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            out_byte_reg <= byte_val;
            out_idx_reg  <= cmd.load_idx;
            out_eor_reg  <= at_last;
            out_eoi_reg  <= at_last && last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_idx   = out_idx_reg;
    assign out_eor   = out_eor_reg;
    assign out_eoi   = out_eoi_reg;

    a_fill_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(CHUNK_BYTES))
        else $error("chunk fill count out of range");

    a_eor_on_last_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eor_reg) |-> (out_idx_reg == POS_LAST))
        else $error("end of report flagged away from last position");

    a_eoi_implies_eor: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_eoi_reg) |-> out_eor_reg)
        else $error("end of image without end of report");

    a_finish_clears_chunk: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (fill_reg == '0) && (crc_reg == CRC_INIT))
        else $error("chunk state not cleared after report");

endmodule

// ----- hw/rtl/flash_write_report_framer.sv -----
// Top level of the flash write report framer: controller plus datapath.
// A closing byte starts the emit state; report byte 0 is loaded once the output register is free.
// Throughput: one image byte per cycle while a chunk fills; the report's 64 bytes then follow,
// one byte per cycle while the receiver is ready, paced by the single output register.
// Input is held off while a report is emitted; a chunk holds up to 46 bytes.
// Reset: asynchronous, active low; clears chunk state and counters, config registers to defaults.
module flash_write_report_framer
    import fwrf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    fwrf_in_if.sink              in_ch,
    fwrf_out_if.source           out_ch
);

    fwrf_cmd_t    cmd;
    fwrf_status_t status;
    logic         in_ready;

    assign in_ch.ready = in_ready;

    fwrf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    fwrf_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_byte   (in_ch.data_byte),
        .in_last   (in_ch.is_last),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_byte  (out_ch.report_byte),
        .out_idx   (out_ch.byte_index),
        .out_eor   (out_ch.end_of_report),
        .out_eoi   (out_ch.end_of_image)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench of the flash write report framer: directed table, then random images.
module tb;
    import fwrf_pkg::*;

    typedef enum logic {ROW_ITEM, ROW_REG} stim_kind_t;

    typedef struct {
        stim_kind_t           kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [WORD_W-1:0]    value;
        logic                 last;
        logic                 known;
        logic [7:0]           e_id;
        logic [15:0]          e_cmd;
        logic [15:0]          e_len;
        logic [WORD_W-1:0]    e_ofs;
    } stim_row_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  pos;
        logic              eor;
        logic              eoi;
    } report_byte_t;

    localparam int DIR_ROWS = 25;
    localparam int DRAIN_CYCLES = 10;

    // known rows: header fields read off the layout directly
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'h00,        1'b1, 1'b1, 8'h05, 16'h0003, 16'd1, 32'h0},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'hFF,        1'b1, 1'b1, 8'h05, 16'h0003, 16'd1, 32'h1},
        '{ROW_REG,  CFG_BASE_ADDRESS,  32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_IMAGE_LENGTH,  32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_REPORT_ID,     32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_WRITE_COMMAND, 32'hFFFF_FFFF, 1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'h5A,        1'b1, 1'b1, 8'hFF, 16'hFFFF, 16'd1, 32'h1},
        '{ROW_REG,  CFG_BASE_ADDRESS,  32'h0,         1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_IMAGE_LENGTH,  32'h0,         1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_REPORT_ID,     32'h0,         1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_WRITE_COMMAND, 32'h0,         1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'h01,        1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'h80,        1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_REPORT_ID,     32'hA5,        1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'h7F,        1'b1, 1'b1, 8'hA5, 16'h0000, 16'd3, 32'h3},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'hAA,        1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'h55,        1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'hF0,        1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'h0F,        1'b1, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_BASE_ADDRESS,  32'h1234_5678, 1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_IMAGE_LENGTH,  32'h0000_0100, 1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_WRITE_COMMAND, 32'h0000_8001, 1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_ITEM, CFG_BASE_ADDRESS,  32'hC3, 1'b1, 1'b1, 8'hA5, 16'h8001, 16'd1, 32'h1234_5682},
        '{ROW_REG,  CFG_REPORT_ID,     32'h5,         1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0},
        '{ROW_REG,  CFG_WRITE_COMMAND, 32'h3,         1'b0, 1'b0, 8'h00, 16'h0000, 16'd0, 32'h0}
    };

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WORD_W-1:0]    cfg_data;

    fwrf_in_if  in_ch ();
    fwrf_out_if out_ch ();

    flash_write_report_framer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // predictor state
    logic [31:0]       reg_base;
    logic [31:0]       reg_img_len;
    logic [7:0]        reg_id;
    logic [15:0]       reg_cmd;
    logic [7:0]        chunk_mem [CHUNK_BYTES];
    logic [5:0]        fill;
    logic [CRC_W-1:0]  run_crc;
    logic [31:0]       bytes_done;
    logic [7:0]        frame_buf [REPORT_BYTES];

    report_byte_t pending_report_bytes [$];
    int  errors = 0;
    int  rx_hold = 0;
    bit  rx_stalls = 1'b1;
    bit  tx_gaps = 1'b1;

    function automatic bit absorb_byte(input logic [7:0] d, input logic l);
        logic [15:0] c;
        logic [31:0] ofs;
        if (fill < CHUNK_BYTES)
            chunk_mem[fill] = d;
        c = run_crc ^ {8'h00, d};
        for (int b = 0; b < 8; b++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        run_crc = c;
        fill = fill + 6'd1;
        if (fill < CHUNK_BYTES && !l)
            return 1'b0;
        foreach (frame_buf[k])
            frame_buf[k] = 8'h00;
        ofs = reg_base + bytes_done;
        frame_buf[0]  = reg_id;
        frame_buf[1]  = reg_cmd[7:0];
        frame_buf[2]  = reg_cmd[15:8];
        frame_buf[5]  = {2'b00, fill};
        frame_buf[7]  = run_crc[7:0];
        frame_buf[8]  = run_crc[15:8];
        for (int k = 0; k < 4; k++)
        begin
            frame_buf[9 + k]  = reg_img_len[8*k +: 8];
            frame_buf[13 + k] = ofs[8*k +: 8];
        end
        for (int i = 0; i < fill; i++)
            if (PAYLOAD_START + i < REPORT_BYTES)
                frame_buf[PAYLOAD_START + i] = chunk_mem[i];
        bytes_done = bytes_done + {26'd0, fill};
        fill = 6'd0;
        run_crc = CRC_INIT;
        return 1'b1;
    endfunction

    function automatic void queue_report(input logic l);
        report_byte_t r;
        for (int k = 0; k < REPORT_BYTES; k++)
        begin
            r.data = frame_buf[k];
            r.pos  = IDX_W'(k);
            r.eor  = (k == REPORT_BYTES - 1);
            r.eoi  = (k == REPORT_BYTES - 1) && l;
            pending_report_bytes.push_back(r);
        end
    endfunction

    task automatic send_byte(input logic [7:0] d, input logic l);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= d;
        in_ch.is_last   <= l;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready))
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (pending_report_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        case (idx)
            CFG_BASE_ADDRESS:  reg_base    = v;
            CFG_IMAGE_LENGTH:  reg_img_len = v;
            CFG_REPORT_ID:     reg_id      = v[7:0];
            CFG_WRITE_COMMAND: reg_cmd     = v[15:0];
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : clock_gen
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin : watchdog
        #2000000;
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin : report_sink
        int stall;
        report_byte_t want;
        report_byte_t got;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                stall = rx_hold;
                rx_hold = 0;
            end
            else
                stall = rx_stalls ? $urandom_range(0, 5) : 0;
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!(out_ch.valid && out_ch.ready))
                @(posedge clk);
            got = '{out_ch.report_byte, out_ch.byte_index, out_ch.end_of_report,
                    out_ch.end_of_image};
            if (pending_report_bytes.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected report byte: data=%h pos=%0d eor=%b eoi=%b",
                             got.data, got.pos, got.eor, got.eoi);
                errors++;
            end
            else
            begin
                want = pending_report_bytes.pop_front();
                if (got.data !== want.data || got.pos !== want.pos ||
                    got.eor !== want.eor || got.eoi !== want.eoi)
                begin
                    if (errors < 10)
                        $display("mismatch: exp data=%h pos=%0d eor=%b eoi=%b, got data=%h pos=%0d eor=%b eoi=%b",
                                 want.data, want.pos, want.eor, want.eoi,
                                 got.data, got.pos, got.eor, got.eoi);
                    errors++;
                end
            end
        end
    end

    initial
    begin : image_source
        stim_row_t row;
        int items_sent;
        int phase;
        int img_len;
        bit noise;
        bit open_end;
        logic [7:0] d;
        logic l;
        logic [31:0] v;

        in_ch.valid     <= 1'b0;
        in_ch.data_byte <= 8'h00;
        in_ch.is_last   <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= CFG_BASE_ADDRESS;
        cfg_data        <= '0;
        reg_base    = 32'd0;
        reg_img_len = 32'd0;
        reg_id      = RESET_REPORT_ID;
        reg_cmd     = RESET_WRITE_COMMAND;
        foreach (chunk_mem[k])
            chunk_mem[k] = 8'h00;
        fill       = 6'd0;
        run_crc    = CRC_INIT;
        bytes_done = 32'd0;
        items_sent = 0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            row = dir_rows[r];
            if (row.kind == ROW_REG)
            begin
                wait_idle();
                write_reg(row.reg_idx, row.value);
            end
            else
            begin
                send_byte(row.value[7:0], row.last);
                items_sent++;
                if (absorb_byte(row.value[7:0], row.last))
                begin
                    if (row.known)
                    begin
                        frame_buf[0] = row.e_id;
                        frame_buf[1] = row.e_cmd[7:0];
                        frame_buf[2] = row.e_cmd[15:8];
                        frame_buf[5] = row.e_len[7:0];
                        frame_buf[6] = row.e_len[15:8];
                        for (int k = 0; k < 4; k++)
                            frame_buf[13 + k] = row.e_ofs[8*k +: 8];
                    end
                    queue_report(row.last);
                end
            end
        end

        phase = 0;
        while (items_sent < 450)
        begin
            phase++;
            wait_idle();
            for (int ri = 0; ri < 4; ri++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h0;
                        1: v = 32'hFFFF_FFFF;
                        default: v = $urandom;
                    endcase
                    write_reg(CFG_IDX_W'(ri), v);
                end
            end
            tx_gaps   = $urandom_range(0, 1);
            rx_stalls = $urandom_range(0, 1);
            case ($urandom_range(0, 9))
                0: img_len = CHUNK_BYTES;
                1: img_len = 2 * CHUNK_BYTES;
                2: img_len = CHUNK_BYTES + 1;
                3: img_len = $urandom_range(2 * CHUNK_BYTES + 1, 140);
                default: img_len = $urandom_range(1, CHUNK_BYTES - 1);
            endcase
            noise    = ($urandom_range(0, 9) == 0);
            open_end = ($urandom_range(0, 7) == 0);
            if (phase == 3)
            begin
                // receiver sits out a long stretch while bytes keep coming
                rx_hold  = 300;
                tx_gaps  = 1'b0;
                img_len  = 120;
                noise    = 1'b0;
                open_end = 1'b0;
            end
            for (int k = 0; k < img_len; k++)
            begin
                d = $urandom_range(0, 255);
                l = ((k == img_len - 1) && !open_end) || (noise && $urandom_range(0, 7) == 0);
                send_byte(d, l);
                items_sent++;
                if (absorb_byte(d, l))
                    queue_report(l);
            end
        end

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0 && pending_report_bytes.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
